// ----- rtl/core/stxfr_pkg.sv -----
`default_nettype none

package stxfr_pkg;

  localparam int PAYLOAD_CAPACITY_DEF = 62;
  localparam int IDX_W = 6;
  localparam int TICK_W = 17;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAK_ENABLE = 2'd3;

  localparam logic [7:0] START_CODE_RST = 8'd2;
  localparam logic [7:0] END_CODE_RST = 8'd3;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
  localparam logic NAK_ENABLE_RST = 1'b1;

  localparam logic [1:0] KIND_NAK = 2'd1;
  localparam logic [1:0] KIND_FRAME = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_END,
    ST_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       command;
    logic [7:0]       length;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic ticks_inc;
    logic ticks_clr;
    logic ld_cmd;
    logic ld_len;
    logic wr_byte;
    logic fill_clr;
    logic fill_inc;
    logic rd_en;
    logic ld_nak;
    logic ld_empty;
    logic ld_item;
  } ctl_cmd_t;

  typedef struct packed {
    logic op;
    logic byte_is_start;
    logic byte_is_end;
    logic byte_zero;
    logic len_zero;
    logic fill_full;
    logic fill_done;
    logic tick_over;
    logic item_last;
    logic nak_en;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/stxfr_ram.sv -----
`default_nettype none

module stxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/stxfr_ctrl.sv -----
`default_nettype none

module stxfr_ctrl
  import stxfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   hold;
  logic   drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take && !sts.op && sts.byte_is_start) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD, ST_LEN, ST_DATA, ST_END: begin
        if (cmd.take) begin
          if (sts.op) begin
            if (sts.tick_over) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            case (state_r)
              ST_CMD: state_nxt = ST_LEN;
              ST_LEN: state_nxt = sts.byte_zero ? ST_END : ST_DATA;
              ST_DATA: begin
                if (sts.fill_full) begin
                  state_nxt = ST_IDLE;
                end else if (sts.fill_done) begin
                  state_nxt = ST_END;
                end
              end
              ST_END: begin
                if (sts.byte_is_end && !sts.len_zero) begin
                  state_nxt = ST_RD;
                end else begin
                  state_nxt = ST_IDLE;
                end
              end
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_RD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.item_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    drop = 1'b0;
    hold = (state_r inside {ST_RD, ST_OUT}) || !sts.out_free;
    cmd.take = in_valid && !hold;
    if (cmd.take) begin
      if (sts.op) begin
        cmd.ticks_inc = 1'b1;
        if (state_r != ST_IDLE && sts.tick_over) begin
          drop = 1'b1;
        end
      end else begin
        cmd.ticks_clr = 1'b1;
        case (state_r)
          ST_IDLE: begin
            if (!sts.byte_is_start) begin
              drop = 1'b1;
            end
          end
          ST_CMD: cmd.ld_cmd = 1'b1;
          ST_LEN: begin
            cmd.ld_len = 1'b1;
            cmd.fill_clr = 1'b1;
          end
          ST_DATA: begin
            cmd.wr_byte = 1'b1;
            cmd.fill_inc = 1'b1;
            if (sts.fill_full) begin
              drop = 1'b1;
            end
          end
          ST_END: begin
            if (sts.byte_is_end) begin
              if (sts.len_zero) begin
                cmd.ld_empty = 1'b1;
              end else begin
                cmd.fill_clr = 1'b1;
              end
            end else begin
              drop = 1'b1;
            end
          end
          default: drop = 1'b0;
        endcase
      end
    end
    if (state_r == ST_RD) begin
      cmd.rd_en = 1'b1;
    end
    if (state_r == ST_OUT && sts.out_free) begin
      cmd.ld_item = 1'b1;
      cmd.fill_inc = 1'b1;
    end
    cmd.ld_nak = drop && sts.nak_en;
  end

  assign in_stall = hold;

endmodule

`default_nettype wire

// ----- rtl/core/stxfr_dp.sv -----
`default_nettype none

module stxfr_dp
  import stxfr_pkg::*;
#(
  parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire in_item_t             in_data,
  input  wire ctl_cmd_t             cmd,
  output dp_sts_t                   sts,
  output logic                      out_valid,
  output out_item_t                 out_data,
  input  wire logic                 out_stall
);

  localparam int AW = (PAYLOAD_CAPACITY > 1) ? $clog2(PAYLOAD_CAPACITY) : 1;
  localparam logic [IDX_W:0] CAP_L = (IDX_W + 1)'(PAYLOAD_CAPACITY);

  logic [7:0]        start_code_r;
  logic [7:0]        end_code_r;
  logic [15:0]       timeout_ticks_r;
  logic              nak_enable_r;
  logic [7:0]        command_r;
  logic [7:0]        length_r;
  logic [IDX_W-1:0]  fill_r;
  logic [TICK_W-1:0] idle_ticks_r;
  logic [TICK_W-1:0] idle_ticks_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  logic [IDX_W:0]    fill_p1;
  logic [TICK_W-1:0] ticks_inc;
  logic [7:0]        rd_byte;

  stxfr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_byte),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_data.rx_byte),
    .rd_en   (cmd.rd_en),
    .rd_addr (fill_r[AW-1:0]),
    .rd_data (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r    <= START_CODE_RST;
      end_code_r      <= END_CODE_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      nak_enable_r    <= NAK_ENABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_CODE:    start_code_r <= cfg_data[7:0];
        CFG_END_CODE:      end_code_r <= cfg_data[7:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_data[15:0];
        CFG_NAK_ENABLE:    nak_enable_r <= cfg_data[0];
        default:           nak_enable_r <= nak_enable_r;
      endcase
    end
  end

  assign fill_p1 = {1'b0, fill_r} + (IDX_W + 1)'(1);
  assign ticks_inc = (idle_ticks_r == '1) ? idle_ticks_r : idle_ticks_r + TICK_W'(1);

  always_comb begin
    idle_ticks_nxt = idle_ticks_r;
    if (cmd.ticks_clr) begin
      idle_ticks_nxt = '0;
    end else if (cmd.ticks_inc) begin
      idle_ticks_nxt = ticks_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_r    <= '0;
      length_r     <= '0;
      fill_r       <= '0;
      idle_ticks_r <= '0;
    end else begin
      idle_ticks_r <= idle_ticks_nxt;
      if (cmd.ld_cmd) begin
        command_r <= in_data.rx_byte;
      end
      if (cmd.ld_len) begin
        length_r <= in_data.rx_byte;
      end
      if (cmd.fill_clr) begin
        fill_r <= '0;
      end else if (cmd.fill_inc) begin
        fill_r <= fill_p1[IDX_W-1:0];
      end
    end
  end

  // output register
  always_comb begin
    out_data_nxt = out_data_r;
    if (cmd.ld_nak) begin
      out_data_nxt = '0;
      out_data_nxt.kind = KIND_NAK;
    end else if (cmd.ld_empty) begin
      out_data_nxt = '0;
      out_data_nxt.kind = KIND_FRAME;
      out_data_nxt.command = command_r;
      out_data_nxt.length = length_r;
      out_data_nxt.last = 1'b1;
    end else if (cmd.ld_item) begin
      out_data_nxt.kind = KIND_FRAME;
      out_data_nxt.command = command_r;
      out_data_nxt.length = length_r;
      out_data_nxt.byte_index = fill_r;
      out_data_nxt.payload_byte = rd_byte;
      out_data_nxt.payload_valid = 1'b1;
      out_data_nxt.last = sts.item_last;
    end
    out_valid_nxt = cmd.ld_nak || cmd.ld_empty || cmd.ld_item || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.op = in_data.op;
    sts.byte_is_start = (in_data.rx_byte == start_code_r);
    sts.byte_is_end = (in_data.rx_byte == end_code_r);
    sts.byte_zero = (in_data.rx_byte == 8'd0);
    sts.len_zero = (length_r == 8'd0);
    sts.fill_full = (fill_p1 >= CAP_L);
    sts.fill_done = ({1'b0, fill_p1} >= length_r);
    sts.tick_over = (ticks_inc > {1'b0, timeout_ticks_r});
    sts.item_last = ({1'b0, fill_p1} == length_r);
    sts.nak_en = nak_enable_r;
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/stx_len_etx_frame_receiver_core.sv -----
// stx/len/etx frame receiver
// in channel (in_valid, in_stall, in_data): one received byte or one timer tick
// per transaction; a byte or tick is taken whenever in_valid is high and in_stall is low
// out channel (out_valid, out_stall, out_data): nak reports and frame items,
// held in one output register; a nak or empty-frame result is valid the cycle
// after the transaction that causes it, the first item of a frame with payload
// follows its end byte via states ST_RD (store read) and ST_OUT (output load)
// on a good end byte the frame walks the payload store byte by byte
// (registered store read, then output register load); in_stall is high
// for the whole walk; an empty frame gives its single result with no walk
// while out_valid is high and out_stall is high, the output holds and in_stall
// is high too, since the output register is full
// cfg port: cfg_we writes cfg_data into register cfg_index; the user must
// write only while idle, the block itself does not enforce it
// reset (rst_n low, synchronous): registers back to defaults, parser idle,
// output register empty; the payload store is not cleared, as only bytes
// written in the current frame are read
`default_nettype none

module stx_len_etx_frame_receiver_core
  import stxfr_pkg::*;
#(
  parameter int PAYLOAD_CAPACITY = PAYLOAD_CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  stxfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stxfr_dp #(
    .PAYLOAD_CAPACITY (PAYLOAD_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

`ifndef NO_ASSERTIONS
  a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.kind == KIND_NAK || out_data.kind == KIND_FRAME))
    else $error("result of unknown kind");

  a_nak_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_NAK) |->
      (out_data.command == 8'd0 && out_data.length == 8'd0 &&
       !out_data.payload_valid && !out_data.last))
    else $error("nak carries frame data");

  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_FRAME && out_data.payload_valid) |->
      ({2'b00, out_data.byte_index} < out_data.length))
    else $error("payload index beyond frame length");

  a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.ld_nak, cmd.ld_empty, cmd.ld_item}) <= 1)
    else $error("two result loads in one cycle");
`endif

endmodule

`default_nettype wire
